/* rtl/hrsp_pkg.sv */
// Package: shared constants and types for the HTTP response stream parser.
package hrsp_pkg;
    localparam int MAX_HEADER_BYTES_DEF     = 2048;
    localparam int MAX_TRAILER_BYTES_DEF    = 1024;
    localparam int MAX_CHUNK_LINE_BYTES_DEF = 64;
    localparam logic [23:0] MAX_BODY_RESET  = 24'd4096;

    localparam logic [2:0] ST_MORE     = 3'd0;
    localparam logic [2:0] ST_DONE     = 3'd1;
    localparam logic [2:0] ST_BAD      = 3'd2;
    localparam logic [2:0] ST_HDR_BIG  = 3'd3;
    localparam logic [2:0] ST_BODY_BIG = 3'd4;

    localparam logic FUNC_DATA  = 1'b0;
    localparam logic FUNC_CLOSE = 1'b1;

    // Registered input item handed from the input stage to the parse core.
    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } in_item_t;

    // Result item handed from the parse core to the output stage.
    typedef struct packed {
        logic [2:0] parse_status;
        logic       body_valid;
        logic [7:0] body_byte;
        logic [9:0] response_code;
    } out_item_t;

    // Lower-case a letter.
    function automatic logic [7:0] to_low(input logic [7:0] c);
        to_low = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    // Character of "content-length" at a position.
    function automatic logic [7:0] len_char(input logic [7:0] p);
        case (p)
            8'd0: len_char = "c";  8'd1: len_char = "o";  8'd2: len_char = "n";
            8'd3: len_char = "t";  8'd4: len_char = "e";  8'd5: len_char = "n";
            8'd6: len_char = "t";  8'd7: len_char = "-";  8'd8: len_char = "l";
            8'd9: len_char = "e";  8'd10: len_char = "n"; 8'd11: len_char = "g";
            8'd12: len_char = "t"; 8'd13: len_char = "h";
            default: len_char = 8'h00;
        endcase
    endfunction

    // Character of "transfer-encoding" at a position.
    function automatic logic [7:0] te_char(input logic [7:0] p);
        case (p)
            8'd0: te_char = "t";  8'd1: te_char = "r";  8'd2: te_char = "a";
            8'd3: te_char = "n";  8'd4: te_char = "s";  8'd5: te_char = "f";
            8'd6: te_char = "e";  8'd7: te_char = "r";  8'd8: te_char = "-";
            8'd9: te_char = "e";  8'd10: te_char = "n"; 8'd11: te_char = "c";
            8'd12: te_char = "o"; 8'd13: te_char = "d"; 8'd14: te_char = "i";
            8'd15: te_char = "n"; 8'd16: te_char = "g";
            default: te_char = 8'h00;
        endcase
    endfunction

    // Character of "chunked" at a position.
    function automatic logic [7:0] chunk_char(input logic [7:0] p);
        case (p)
            8'd0: chunk_char = "c"; 8'd1: chunk_char = "h"; 8'd2: chunk_char = "u";
            8'd3: chunk_char = "n"; 8'd4: chunk_char = "k"; 8'd5: chunk_char = "e";
            8'd6: chunk_char = "d";
            default: chunk_char = 8'h00;
        endcase
    endfunction

    // Character of "HTTP/1." at a position.
    function automatic logic [7:0] proto_char(input logic [7:0] p);
        case (p)
            8'd0: proto_char = "H"; 8'd1: proto_char = "T"; 8'd2: proto_char = "T";
            8'd3: proto_char = "P"; 8'd4: proto_char = "/"; 8'd5: proto_char = "1";
            8'd6: proto_char = ".";
            default: proto_char = 8'h00;
        endcase
    endfunction

    // Hex digit value, 16 when not a hex digit.
    function automatic logic [4:0] hex_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")      hex_of = 5'(c - "0");
        else if (c >= "a" && c <= "f") hex_of = 5'(c - "a" + 8'd10);
        else if (c >= "A" && c <= "F") hex_of = 5'(c - "A" + 8'd10);
        else                           hex_of = 5'd16;
    endfunction
endpackage

/* rtl/http_response_stream_parser_unit.sv */
// Top level: input register, parse core and result register.
// One byte or close marker enters and its result leaves from a result register; sustained rate
// is one item per clock while the receiver does not stall, set by the parse step between the
// input register and the result register. The input register takes a new item whenever it
// is empty or its item moves into the result register in the same cycle.
module http_response_stream_parser_unit #(
    parameter int MAX_HEADER_BYTES     = hrsp_pkg::MAX_HEADER_BYTES_DEF,
    parameter int MAX_TRAILER_BYTES    = hrsp_pkg::MAX_TRAILER_BYTES_DEF,
    parameter int MAX_CHUNK_LINE_BYTES = hrsp_pkg::MAX_CHUNK_LINE_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  parse_status,
    output logic        body_valid,
    output logic [7:0]  body_byte,
    output logic [9:0]  response_code
);
    import hrsp_pkg::*;

    logic        in_full_reg;
    in_item_t    in_item_reg;
    logic        out_full_reg;
    out_item_t   out_item_reg;
    out_item_t   core_result;
    logic [23:0] max_body_reg;
    logic        step;

    assign step     = in_full_reg && (!out_full_reg || !out_stall);
    assign in_stall = in_full_reg && !step;

    // Hold the body limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) max_body_reg <= MAX_BODY_RESET;
        else if (cfg_we) max_body_reg <= cfg_data;
    end

    // Advance the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) in_full_reg <= 1'b0;
        else if (in_valid && !in_stall) in_full_reg <= 1'b1;
        else if (step) in_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall) in_item_reg <= '{func: func, data_byte: data_byte};
    end

    hrsp_core #(
        .MAX_HEADER_BYTES    (MAX_HEADER_BYTES),
        .MAX_TRAILER_BYTES   (MAX_TRAILER_BYTES),
        .MAX_CHUNK_LINE_BYTES(MAX_CHUNK_LINE_BYTES)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .item          (in_item_reg),
        .max_body_bytes(max_body_reg),
        .result        (core_result)
    );

    // Advance the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_full_reg <= 1'b0;
        else if (step) out_full_reg <= 1'b1;
        else if (!out_stall) out_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step) out_item_reg <= core_result;
    end

    assign out_valid     = out_full_reg;
    assign parse_status  = out_item_reg.parse_status;
    assign body_valid    = out_item_reg.body_valid;
    assign body_byte     = out_item_reg.body_byte;
    assign response_code = out_item_reg.response_code;
endmodule

/* rtl/hrsp_core.sv */
// Parse core: parser state and the per-byte next-state logic.
module hrsp_core #(
    parameter int MAX_HEADER_BYTES     = hrsp_pkg::MAX_HEADER_BYTES_DEF,
    parameter int MAX_TRAILER_BYTES    = hrsp_pkg::MAX_TRAILER_BYTES_DEF,
    parameter int MAX_CHUNK_LINE_BYTES = hrsp_pkg::MAX_CHUNK_LINE_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  hrsp_pkg::in_item_t  item,
    input  logic [23:0]         max_body_bytes,
    output hrsp_pkg::out_item_t result
);
    import hrsp_pkg::*;

    localparam int HCW = $clog2(MAX_HEADER_BYTES + 1);
    localparam int TCW = $clog2(MAX_TRAILER_BYTES + 2);
    localparam int LLW = (MAX_CHUNK_LINE_BYTES > 255) ? $clog2(MAX_CHUNK_LINE_BYTES + 1) : 8;

    typedef enum logic [3:0] {
        PH_HEADERS, PH_FIXED, PH_TILL_CLOSE, PH_CSIZE, PH_CDATA,
        PH_CCR, PH_CLF, PH_TRAIL, PH_END
    } phase_t;

    localparam logic [1:0] VK_OTHER = 2'd0;
    localparam logic [1:0] VK_LEN   = 2'd1;
    localparam logic [1:0] VK_TE    = 2'd2;

    phase_t      phase_reg, phase_next;
    logic [2:0]  sticky_reg, sticky_next;
    logic [HCW-1:0] hcount_reg, hcount_next;
    logic [2:0]  scan_reg, scan_next;
    logic [1:0]  tail_reg, tail_next;
    logic [9:0]  code_reg, code_next;
    logic        len_seen_reg, len_seen_next;
    logic        chk_seen_reg, chk_seen_next;
    logic [63:0] acc_reg, acc_next;
    logic [23:0] body_cnt_reg, body_cnt_next;
    logic [23:0] left_reg, left_next;
    logic [LLW-1:0] line_len_reg, line_len_next;
    logic [1:0]  ext_reg, ext_next;
    logic [TCW-1:0] trail_reg, trail_next;
    logic        saw_cr_reg, saw_cr_next;
    logic        hbad_reg, hbad_next;
    logic        code_ok_reg, code_ok_next;
    logic        lbad_reg, lbad_next;
    logic        valive_reg, valive_next;
    logic [1:0]  nalive_reg, nalive_next;
    logic [1:0]  vkind_reg, vkind_next;
    logic [4:0]  nmatch_reg, nmatch_next;
    logic [3:0]  vmatch_reg, vmatch_next;
    logic        bvalid;

    // Decimal or hex digit into the accumulator; returns 0 on overflow.
    function automatic logic add_dec(input logic [63:0] a, input logic [3:0] d,
                                     output logic [63:0] r);
        logic [67:0] w;
        w = {3'd0, a, 1'b0} + {1'b0, a, 3'd0} + {64'd0, d};
        r = w[63:0];
        add_dec = (w[67:64] == 4'd0);
    endfunction

    function automatic logic add_hex(input logic [63:0] a, input logic [3:0] d,
                                     output logic [63:0] r);
        r = {a[59:0], d};
        add_hex = (a[63:60] == 4'd0);
    endfunction

    // Compute the next state for one accepted byte.
    always_comb
    begin
        logic [7:0] c, lc, nm8, vm8;
        logic [63:0] sum;
        logic [4:0] hd;
        logic [24:0] room;
        logic [23:0] left_dec;
        logic trailer, do_char, ok, cr_first;
        logic [2:0] scan_m;
        logic [LLW-1:0] line_len_m;
        logic [1:0] nalive_m;
        logic [4:0] nmatch_m;
        logic [3:0] vmatch_m;
        logic valive_m, hbad_m;
        phase_next = phase_reg;       sticky_next = sticky_reg;
        hcount_next = hcount_reg;     scan_next = scan_reg;
        tail_next = tail_reg;         code_next = code_reg;
        len_seen_next = len_seen_reg; chk_seen_next = chk_seen_reg;
        acc_next = acc_reg;           body_cnt_next = body_cnt_reg;
        left_next = left_reg;         line_len_next = line_len_reg;
        ext_next = ext_reg;           trail_next = trail_reg;
        saw_cr_next = saw_cr_reg;     hbad_next = hbad_reg;
        code_ok_next = code_ok_reg;   lbad_next = lbad_reg;
        valive_next = valive_reg;     nalive_next = nalive_reg;
        vkind_next = vkind_reg;       nmatch_next = nmatch_reg;
        vmatch_next = vmatch_reg;
        scan_m = scan_reg;            line_len_m = line_len_reg;
        nalive_m = nalive_reg;        nmatch_m = nmatch_reg;
        vmatch_m = vmatch_reg;        valive_m = valive_reg;
        hbad_m = hbad_reg;
        bvalid = 1'b0;
        c = item.data_byte;
        lc = 8'd0; nm8 = 8'd0; vm8 = 8'd0; sum = 64'd0; hd = 5'd0;
        room = 25'd0; left_dec = 24'd0; ok = 1'b0; do_char = 1'b0; cr_first = 1'b0;
        trailer = (phase_reg == PH_TRAIL);
        if (step && sticky_reg == ST_MORE) begin
            if (item.func == FUNC_CLOSE) begin
                phase_next = PH_END;
                sticky_next = (phase_reg == PH_TILL_CLOSE) ? ST_DONE : ST_BAD;
            end else begin
                unique case (phase_reg)
                    PH_HEADERS:
                    begin
                        if (hcount_reg >= HCW'(MAX_HEADER_BYTES)) begin
                            phase_next = PH_END; sticky_next = ST_HDR_BIG;
                        end else begin
                            hcount_next = hcount_reg + 1'b1;
                            if (c == 8'h0D)      tail_next = (tail_reg == 2'd2) ? 2'd3 : 2'd1;
                            else if (c == 8'h0A) tail_next = tail_reg[0] ? 2'd2 : 2'd0;
                            else                 tail_next = 2'd0;
                            if (c == 8'h0A && tail_reg == 2'd3) begin
                                // End of the header block: pick the body form.
                                saw_cr_next = 1'b0;
                                if (hbad_reg || (len_seen_reg && chk_seen_reg)) begin
                                    phase_next = PH_END; sticky_next = ST_BAD;
                                end else begin
                                    code_ok_next = 1'b1;
                                    if (len_seen_reg && acc_reg > {40'd0, max_body_bytes}) begin
                                        phase_next = PH_END; sticky_next = ST_BODY_BIG;
                                    end else if (code_reg == 10'd204 || code_reg == 10'd304 ||
                                                 (len_seen_reg && acc_reg == 64'd0)) begin
                                        phase_next = PH_END; sticky_next = ST_DONE;
                                    end else if (chk_seen_reg) begin
                                        scan_next = 3'd0; ext_next = 2'd0; line_len_next = '0;
                                        acc_next = 64'd0; lbad_next = 1'b0;
                                        phase_next = PH_CSIZE;
                                    end else if (len_seen_reg) begin
                                        left_next = acc_reg[23:0]; phase_next = PH_FIXED;
                                    end else begin
                                        phase_next = PH_TILL_CLOSE;
                                    end
                                end
                            end else if (saw_cr_reg && c == 8'h0A) begin
                                // End of one header line.
                                saw_cr_next = 1'b0;
                                if (scan_reg == 3'd0) begin
                                    if (line_len_reg < LLW'(12) || code_reg < 10'd200 ||
                                        code_reg > 10'd599)
                                        hbad_next = 1'b1;
                                end else if (scan_reg < 3'd4) begin
                                    hbad_next = 1'b1;
                                end else if (vkind_reg == VK_LEN) begin
                                    if (scan_reg == 3'd4) hbad_next = 1'b1;
                                end else if (vkind_reg == VK_TE) begin
                                    if (scan_reg == 3'd4 || !valive_reg || vmatch_reg != 4'd7)
                                        hbad_next = 1'b1;
                                end
                                scan_next = 3'd1; nmatch_next = 5'd0; nalive_next = 2'd3;
                                vkind_next = VK_OTHER; vmatch_next = 4'd0;
                                valive_next = 1'b1; line_len_next = '0;
                            end else begin
                                // A held CR is a plain character ahead of this byte.
                                if (saw_cr_reg) begin
                                    cr_first = 1'b1;
                                    saw_cr_next = (c == 8'h0D);
                                    do_char = (c != 8'h0D);
                                end else if (c == 8'h0D) begin
                                    saw_cr_next = 1'b1;
                                end else begin
                                    do_char = 1'b1;
                                end
                            end
                        end
                    end
                    PH_FIXED, PH_TILL_CLOSE, PH_CDATA:
                    begin
                        if (body_cnt_reg >= max_body_bytes) begin
                            phase_next = PH_END; sticky_next = ST_BODY_BIG;
                        end else begin
                            body_cnt_next = body_cnt_reg + 24'd1;
                            bvalid = 1'b1;
                            if (phase_reg != PH_TILL_CLOSE) begin
                                left_dec = (left_reg != 24'd0) ? left_reg - 24'd1 : left_reg;
                                left_next = left_dec;
                                if (left_dec == 24'd0) begin
                                    if (phase_reg == PH_FIXED) begin
                                        phase_next = PH_END; sticky_next = ST_DONE;
                                    end else begin
                                        phase_next = PH_CCR;
                                    end
                                end
                            end
                        end
                    end
                    PH_CSIZE, PH_TRAIL:
                    begin
                        if (trailer && trail_reg >= TCW'(MAX_TRAILER_BYTES)) begin
                            phase_next = PH_END; sticky_next = ST_HDR_BIG;
                        end else begin
                            if (trailer) trail_next = trail_reg + 1'b1;
                            if (saw_cr_reg) begin
                                if (c != 8'h0A) begin
                                    phase_next = PH_END; sticky_next = ST_BAD;
                                end else if (trailer) begin
                                    saw_cr_next = 1'b0;
                                    if (line_len_reg == '0) begin
                                        phase_next = PH_END; sticky_next = ST_DONE;
                                    end
                                    line_len_next = '0;
                                end else if (lbad_reg || scan_reg == 3'd0 || ext_reg == 2'd1) begin
                                    phase_next = PH_END; sticky_next = ST_BAD;
                                end else begin
                                    room = (max_body_bytes > body_cnt_reg) ?
                                           {1'b0, max_body_bytes - body_cnt_reg} : 25'd0;
                                    if (acc_reg > {39'd0, room}) begin
                                        phase_next = PH_END; sticky_next = ST_BODY_BIG;
                                    end else begin
                                        left_next = acc_reg[23:0];
                                        phase_next = (acc_reg[23:0] == 24'd0) ? PH_TRAIL : PH_CDATA;
                                        scan_next = 3'd0; ext_next = 2'd0; line_len_next = '0;
                                        acc_next = 64'd0; lbad_next = 1'b0; saw_cr_next = 1'b0;
                                    end
                                end
                            end else if (c == 8'h0D) begin
                                saw_cr_next = 1'b1;
                            end else if (c == 8'h0A || line_len_reg >= LLW'(MAX_CHUNK_LINE_BYTES)
                                         || c < 8'h20) begin
                                phase_next = PH_END; sticky_next = ST_BAD;
                            end else begin
                                line_len_next = line_len_reg + 1'b1;
                                if (!trailer) begin
                                    // Size digits, then an optional extension.
                                    if (ext_reg != 2'd0) begin
                                        if (c >= 8'h7F) lbad_next = 1'b1;
                                        ext_next = 2'd2;
                                    end else if (c == ";") begin
                                        ext_next = 2'd1;
                                    end else if (c == 8'h20 || c == 8'h09) begin
                                        if (scan_reg == 3'd1) scan_next = 3'd2;
                                    end else begin
                                        hd = hex_of(c);
                                        ok = add_hex(acc_reg, hd[3:0], sum);
                                        if (hd[4] || scan_reg == 3'd2 || !ok) lbad_next = 1'b1;
                                        else begin
                                            acc_next = sum; scan_next = 3'd1;
                                        end
                                    end
                                end
                            end
                        end
                    end
                    PH_CCR:
                    begin
                        if (c != 8'h0D) begin
                            phase_next = PH_END; sticky_next = ST_BAD;
                        end else phase_next = PH_CLF;
                    end
                    PH_CLF:
                    begin
                        if (c != 8'h0A) begin
                            phase_next = PH_END; sticky_next = ST_BAD;
                        end else begin
                            scan_next = 3'd0; ext_next = 2'd0; line_len_next = '0;
                            acc_next = 64'd0; lbad_next = 1'b0; saw_cr_next = 1'b0;
                            phase_next = PH_CSIZE;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_END; sticky_next = ST_BAD;
                    end
                endcase
            end
            // Scan the held CR as a header character before the new byte.
            if (cr_first) begin
                if (scan_reg == 3'd0) begin
                    if (line_len_reg < LLW'(12)) hbad_m = 1'b1;
                end else if (scan_reg <= 3'd3) begin
                    nalive_m = 2'd0;
                    if (scan_reg != 3'd3) begin
                        if (nmatch_reg < 5'd18) nmatch_m = nmatch_reg + 5'd1;
                        scan_m = 3'd2;
                    end
                end else begin
                    if (vkind_reg == VK_LEN) begin
                        hbad_m = 1'b1;
                    end else if (vkind_reg == VK_TE) begin
                        valive_m = 1'b0;
                        if (vmatch_reg < 4'd8) vmatch_m = vmatch_reg + 4'd1;
                    end
                    if (scan_reg != 3'd6) scan_m = 3'd5;
                end
                if (line_len_reg < LLW'(255)) line_len_m = line_len_reg + 1'b1;
                scan_next = scan_m;     line_len_next = line_len_m;
                nalive_next = nalive_m; nmatch_next = nmatch_m;
                vmatch_next = vmatch_m; valive_next = valive_m;
                hbad_next = hbad_m;
            end
            // Header character: status line, name or value.
            if (do_char) begin
                if (scan_m == 3'd0) begin
                    if (line_len_m < LLW'(7)) begin
                        if (c != proto_char(8'(line_len_m))) hbad_next = 1'b1;
                    end else if (line_len_m == LLW'(7)) begin
                        if (c != "0" && c != "1") hbad_next = 1'b1;
                    end else if (line_len_m == LLW'(8)) begin
                        if (c != " ") hbad_next = 1'b1;
                    end else if (line_len_m < LLW'(12)) begin
                        if (c >= "0" && c <= "9")
                            code_next = 10'(code_reg * 10'd10 + 10'(c - "0"));
                        else hbad_next = 1'b1;
                    end
                end else if (scan_m <= 3'd3) begin
                    if (c == ":") begin
                        if (line_len_m == '0) hbad_next = 1'b1;
                        if (nalive_m[0] && nmatch_m == 5'd14) begin
                            vkind_next = VK_LEN;
                            if (len_seen_reg) hbad_next = 1'b1;
                            len_seen_next = 1'b1; acc_next = 64'd0;
                        end else if (nalive_m[1] && nmatch_m == 5'd17) begin
                            vkind_next = VK_TE;
                            if (chk_seen_reg) hbad_next = 1'b1;
                            chk_seen_next = 1'b1;
                        end
                        scan_next = 3'd4;
                    end else if (c == 8'h20 || c == 8'h09) begin
                        if (scan_m == 3'd2) scan_next = 3'd3;
                    end else if (scan_m == 3'd3) begin
                        nalive_next = 2'd0;
                    end else begin
                        lc = to_low(c);
                        nm8 = {3'd0, nmatch_m};
                        nalive_next = nalive_m;
                        if (nmatch_m >= 5'd14 || lc != len_char(nm8)) nalive_next[0] = 1'b0;
                        if (nmatch_m >= 5'd17 || lc != te_char(nm8)) nalive_next[1] = 1'b0;
                        // Saturate: any name longer than 17 matches neither.
                        if (nmatch_m < 5'd18) nmatch_next = nmatch_m + 5'd1;
                        scan_next = 3'd2;
                    end
                end else begin
                    if (c == 8'h20 || c == 8'h09) begin
                        if (scan_m == 3'd5) scan_next = 3'd6;
                    end else begin
                        if (vkind_reg == VK_LEN) begin
                            ok = add_dec(acc_reg, c[3:0], sum);
                            if (scan_m == 3'd6 || c < "0" || c > "9" || !ok) hbad_next = 1'b1;
                            if (!(scan_m == 3'd6 || c < "0" || c > "9") && ok)
                                acc_next = sum;
                        end else if (vkind_reg == VK_TE) begin
                            vm8 = {4'd0, vmatch_m};
                            if (scan_m == 3'd6 || vmatch_m >= 4'd7 ||
                                to_low(c) != chunk_char(vm8))
                                valive_next = 1'b0;
                            if (vmatch_m < 4'd8) vmatch_next = vmatch_m + 4'd1;
                        end
                        if (scan_m != 3'd6) scan_next = 3'd5;
                    end
                end
                if (line_len_m < LLW'(255)) line_len_next = line_len_m + 1'b1;
            end
        end
    end

    // Hold parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_HEADERS;  sticky_reg <= ST_MORE;
            hcount_reg <= '0;         scan_reg <= 3'd0;
            tail_reg <= 2'd0;         code_reg <= 10'd0;
            len_seen_reg <= 1'b0;     chk_seen_reg <= 1'b0;
            acc_reg <= 64'd0;         body_cnt_reg <= 24'd0;
            left_reg <= 24'd0;        line_len_reg <= '0;
            ext_reg <= 2'd0;          trail_reg <= '0;
            saw_cr_reg <= 1'b0;       hbad_reg <= 1'b0;
            code_ok_reg <= 1'b0;      lbad_reg <= 1'b0;
            valive_reg <= 1'b1;       nalive_reg <= 2'd3;
            vkind_reg <= VK_OTHER;    nmatch_reg <= 5'd0;
            vmatch_reg <= 4'd0;
        end else if (step) begin
            phase_reg <= phase_next;  sticky_reg <= sticky_next;
            hcount_reg <= hcount_next; scan_reg <= scan_next;
            tail_reg <= tail_next;    code_reg <= code_next;
            len_seen_reg <= len_seen_next; chk_seen_reg <= chk_seen_next;
            acc_reg <= acc_next;      body_cnt_reg <= body_cnt_next;
            left_reg <= left_next;    line_len_reg <= line_len_next;
            ext_reg <= ext_next;      trail_reg <= trail_next;
            saw_cr_reg <= saw_cr_next; hbad_reg <= hbad_next;
            code_ok_reg <= code_ok_next; lbad_reg <= lbad_next;
            valive_reg <= valive_next; nalive_reg <= nalive_next;
            vkind_reg <= vkind_next;  nmatch_reg <= nmatch_next;
            vmatch_reg <= vmatch_next;
        end
    end

    // Form the result item.
    always_comb
    begin
        result.parse_status  = sticky_next;
        result.body_valid    = bvalid;
        result.body_byte     = bvalid ? item.data_byte : 8'd0;
        result.response_code = code_ok_next ? code_next : 10'd0;
    end
endmodule

/* rtl/hrsp_checker.sv */
// Checker on the top-level ports, with its bind.
module hrsp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] parse_status,
    input logic       body_valid,
    input logic [7:0] body_byte,
    input logic [9:0] response_code
);
    import hrsp_pkg::*;

    // Hold a stalled result.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(parse_status))
        else $error("stalled result changed");

    // Body byte only while parsing or on the last byte of a fixed body.
    a_body_more: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && body_valid |-> parse_status == ST_MORE || parse_status == ST_DONE)
        else $error("body byte with failed status");

    // Idle body byte reads zero.
    a_body_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !body_valid |-> body_byte == 8'd0)
        else $error("body byte not zero");

    // Body carries a known code.
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && body_valid |-> response_code >= 10'd200 && response_code <= 10'd599)
        else $error("body without valid code");
endmodule

bind http_response_stream_parser_unit hrsp_checker u_hrsp_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .parse_status(parse_status), .body_valid(body_valid), .body_byte(body_byte),
    .response_code(response_code)
);

/* bench/http_response_stream_parser_unit_tb.sv */
// Testbench for the HTTP response stream parser: directed table, random chunked body, checker.
module http_response_stream_parser_unit_tb;
    import hrsp_pkg::*;

    // Parse phases of the predictor
    typedef enum logic [3:0] {
        PH_HEADERS, PH_FIXED, PH_TILL_CLOSE, PH_CSIZE, PH_CDATA,
        PH_CCR, PH_CLF, PH_TRAIL, PH_END
    } phase_e;

    // Kind of header value being scanned
    typedef enum logic [1:0] {VK_OTHER, VK_LEN, VK_TE} vkind_e;

    // Ways the random part closes the response
    typedef enum int {END_TRAILER, END_NO_ROOM, END_CLOSE} ending_e;

    typedef struct packed {
        logic [2:0] status;
        logic       bvalid;
        logic [7:0] bbyte;
        logic [9:0] code;
    } result_t;

    typedef struct {
        bit      typed;
        result_t want;
    } note_t;

    typedef struct {
        string   txt;
        bit      typed;
        result_t want;
    } row_t;

    localparam int LIMIT_CYCLES = 200000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [23:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        func;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  parse_status;
    logic        body_valid;
    logic [7:0]  body_byte;
    logic [9:0]  response_code;

    http_response_stream_parser_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .parse_status  (parse_status),
        .body_valid    (body_valid),
        .body_byte     (body_byte),
        .response_code (response_code)
    );

    // Parser mirror state
    logic [23:0] max_body;
    phase_e      ph;
    logic [2:0]  sticky;
    int unsigned hdr_cnt;
    int unsigned scan;
    int unsigned tail;
    int unsigned code;
    bit          len_seen;
    bit          te_seen;
    logic [63:0] acc;
    bit          ovf;
    int unsigned body_cnt;
    int unsigned left;
    int unsigned line_len;
    int unsigned ext;
    int unsigned trl_cnt;
    bit          saw_cr;
    bit          hdr_bad;
    bit          code_ok;
    bit          line_bad;
    bit          val_alive;
    int unsigned name_alive;
    vkind_e      val_kind;
    int unsigned name_pos;
    int unsigned val_pos;

    string proto_s = "HTTP/1.";
    string len_s   = "content-length";
    string te_s    = "transfer-encoding";
    string chk_s   = "chunked";

    // Bench bookkeeping
    result_t     resp_q[$];
    note_t       note_q[$];
    int          errors;
    int          sent_n;
    int          body_seen;
    int          cycles;
    bit          calm;
    bit          squeeze;

    function automatic bit is_ws(int unsigned c);
        return c == 8'h20 || c == 8'h09;
    endfunction

    function automatic int unsigned lower(int unsigned c);
        return (c >= "A" && c <= "Z") ? c + 32 : c;
    endfunction

    function automatic int unsigned hex_val(int unsigned c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return 16;
    endfunction

    // Fold a digit into the accumulator, flag 64-bit overflow
    function bit fold_digit(logic [63:0] base, logic [63:0] d);
        if (acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / base) begin
            ovf = 1'b1;
            return 1'b0;
        end
        acc = acc * base + d;
        return 1'b1;
    endfunction

    function void stop_with(logic [2:0] s);
        ph = PH_END;
        sticky = s;
    endfunction

    function void open_header_line();
        scan = 1; name_pos = 0; name_alive = 3;
        val_kind = VK_OTHER; val_pos = 0; val_alive = 1'b1; line_len = 0;
    endfunction

    function void open_chunk_line();
        scan = 0; ext = 0; line_len = 0;
        acc = '0; ovf = 1'b0; line_bad = 1'b0; saw_cr = 1'b0;
    endfunction

    function void status_line_char(int unsigned c);
        if (line_len < 7) begin
            if (c != proto_s[line_len]) hdr_bad = 1'b1;
        end else if (line_len == 7) begin
            if (c != "0" && c != "1") hdr_bad = 1'b1;
        end else if (line_len == 8) begin
            if (c != " ") hdr_bad = 1'b1;
        end else if (line_len < 12) begin
            if (c >= "0" && c <= "9") code = (code * 10 + (c - "0")) & 10'h3FF;
            else hdr_bad = 1'b1;
        end
    endfunction

    function void hdr_char(int unsigned c);
        int unsigned s;
        int unsigned lc;
        s = scan;
        if (s == 0) begin
            status_line_char(c);
        end else if (s <= 3) begin
            if (c == ":") begin
                if (line_len == 0) hdr_bad = 1'b1;
                if ((name_alive & 1) && name_pos == 14) begin
                    val_kind = VK_LEN;
                    if (len_seen) hdr_bad = 1'b1;
                    len_seen = 1'b1;
                    acc = '0;
                end else if ((name_alive & 2) && name_pos == 17) begin
                    val_kind = VK_TE;
                    if (te_seen) hdr_bad = 1'b1;
                    te_seen = 1'b1;
                end
                scan = 4;
            end else if (is_ws(c)) begin
                if (s == 2) scan = 3;
            end else if (s == 3) begin
                name_alive = 0;
            end else begin
                lc = lower(c);
                if (name_pos >= 14 || lc != len_s[name_pos]) name_alive &= 2;
                if (name_pos >= 17 || lc != te_s[name_pos]) name_alive &= 1;
                if (name_pos < 255) name_pos++;
                scan = 2;
            end
        end else begin
            if (is_ws(c)) begin
                if (s == 5) scan = 6;
            end else begin
                if (val_kind == VK_LEN) begin
                    if (s == 6 || c < "0" || c > "9") hdr_bad = 1'b1;
                    else if (!fold_digit(10, c - "0")) hdr_bad = 1'b1;
                end else if (val_kind == VK_TE) begin
                    if (s == 6 || val_pos >= 7 || lower(c) != chk_s[val_pos])
                        val_alive = 1'b0;
                    if (val_pos < 255) val_pos++;
                end
                if (s != 6) scan = 5;
            end
        end
        if (line_len < 255) line_len++;
    endfunction

    function void hdr_line_end();
        if (scan == 0) begin
            if (line_len < 12 || code < 200 || code > 599) hdr_bad = 1'b1;
        end else if (scan < 4) begin
            hdr_bad = 1'b1;
        end else if (val_kind == VK_LEN) begin
            if (scan == 4) hdr_bad = 1'b1;
        end else if (val_kind == VK_TE) begin
            if (scan == 4 || !val_alive || val_pos != 7) hdr_bad = 1'b1;
        end
        open_header_line();
    endfunction

    function void hdrs_done();
        saw_cr = 1'b0;
        if (len_seen && te_seen) hdr_bad = 1'b1;
        if (hdr_bad) begin
            stop_with(ST_BAD);
            return;
        end
        code_ok = 1'b1;
        if (len_seen && acc > {40'd0, max_body}) begin
            stop_with(ST_BODY_BIG);
            return;
        end
        if (code == 204 || code == 304 || (len_seen && acc == 0)) begin
            stop_with(ST_DONE);
        end else if (te_seen) begin
            open_chunk_line();
            ph = PH_CSIZE;
        end else if (len_seen) begin
            left = acc[23:0];
            ph = PH_FIXED;
        end else begin
            ph = PH_TILL_CLOSE;
        end
    endfunction

    function void hdr_byte(int unsigned c);
        int unsigned t;
        t = tail;
        if (hdr_cnt >= MAX_HEADER_BYTES_DEF) begin
            stop_with(ST_HDR_BIG);
            return;
        end
        hdr_cnt++;
        if (c == 8'h0D) tail = (t == 2) ? 3 : 1;
        else if (c == 8'h0A) tail = (t == 1 || t == 3) ? 2 : 0;
        else tail = 0;
        if (c == 8'h0A && t == 3) begin
            hdrs_done();
            return;
        end
        if (saw_cr) begin
            saw_cr = 1'b0;
            if (c == 8'h0A) begin
                hdr_line_end();
                return;
            end
            hdr_char(8'h0D);
        end
        if (c == 8'h0D) saw_cr = 1'b1;
        else hdr_char(c);
    endfunction

    function void size_char(int unsigned c);
        int unsigned d;
        if (ext != 0) begin
            if (c >= 8'h7F) line_bad = 1'b1;
            ext = 2;
        end else if (c == ";") begin
            ext = 1;
        end else if (is_ws(c)) begin
            if (scan == 1) scan = 2;
        end else begin
            d = hex_val(c);
            if (d > 15 || scan == 2 || !fold_digit(16, d)) line_bad = 1'b1;
            else scan = 1;
        end
    endfunction

    function void chunk_line_end(bit trailer);
        int unsigned room;
        saw_cr = 1'b0;
        if (trailer) begin
            if (line_len == 0) stop_with(ST_DONE);
            line_len = 0;
            return;
        end
        if (line_bad || scan == 0 || ext == 1) begin
            stop_with(ST_BAD);
            return;
        end
        room = (max_body > body_cnt) ? max_body - body_cnt : 0;
        if (acc > room) begin
            stop_with(ST_BODY_BIG);
            return;
        end
        left = acc[31:0];
        ph = (left == 0) ? PH_TRAIL : PH_CDATA;
        open_chunk_line();
    endfunction

    function void line_byte(int unsigned c, bit trailer);
        if (trailer) begin
            trl_cnt++;
            if (trl_cnt > MAX_TRAILER_BYTES_DEF) begin
                stop_with(ST_HDR_BIG);
                return;
            end
        end
        if (saw_cr) begin
            if (c != 8'h0A) stop_with(ST_BAD);
            else chunk_line_end(trailer);
        end else if (c == 8'h0D) begin
            saw_cr = 1'b1;
        end else if (c == 8'h0A || line_len >= MAX_CHUNK_LINE_BYTES_DEF || c < 8'h20) begin
            stop_with(ST_BAD);
        end else begin
            line_len++;
            if (!trailer) size_char(c);
        end
    endfunction

    function void parser_reset();
        max_body = MAX_BODY_RESET;
        ph = PH_HEADERS; sticky = ST_MORE;
        hdr_cnt = 0; tail = 0; code = 0;
        len_seen = 1'b0; te_seen = 1'b0; acc = '0; ovf = 1'b0;
        body_cnt = 0; left = 0; ext = 0; trl_cnt = 0; saw_cr = 1'b0;
        hdr_bad = 1'b0; code_ok = 1'b0; line_bad = 1'b0;
        open_header_line();
        scan = 0;
    endfunction

    // Advance the mirror by one item and return the result it gives
    function result_t parse_item(logic f, logic [7:0] b);
        result_t r;
        bit      bv;
        bv = 1'b0;
        if (sticky == ST_MORE) begin
            if (f == FUNC_CLOSE) begin
                stop_with((ph == PH_TILL_CLOSE) ? ST_DONE : ST_BAD);
            end else begin
                case (ph)
                    PH_HEADERS: hdr_byte(b);
                    PH_FIXED, PH_TILL_CLOSE, PH_CDATA: begin
                        if (body_cnt >= max_body) begin
                            stop_with(ST_BODY_BIG);
                        end else begin
                            body_cnt++;
                            bv = 1'b1;
                            if (ph != PH_TILL_CLOSE) begin
                                if (left != 0) left--;
                                if (left == 0) begin
                                    if (ph == PH_FIXED) stop_with(ST_DONE);
                                    else ph = PH_CCR;
                                end
                            end
                        end
                    end
                    PH_CSIZE: line_byte(b, 1'b0);
                    PH_TRAIL: line_byte(b, 1'b1);
                    PH_CCR: begin
                        if (b != 8'h0D) stop_with(ST_BAD);
                        else ph = PH_CLF;
                    end
                    PH_CLF: begin
                        if (b != 8'h0A) begin
                            stop_with(ST_BAD);
                        end else begin
                            open_chunk_line();
                            ph = PH_CSIZE;
                        end
                    end
                    default: stop_with(ST_BAD);
                endcase
            end
        end
        r.status = sticky;
        r.bvalid = bv;
        r.bbyte  = bv ? b : 8'h00;
        r.code   = code_ok ? code[9:0] : 10'd0;
        return r;
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("http_response_stream_parser_unit_tb: errors");
            $finish;
        end
    end

    // Predict on accepted items, check accepted results
    always @(posedge clk)
    begin
        note_t   nt;
        result_t want;
        result_t got;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                nt = note_q.pop_front();
                want = parse_item(func, data_byte);
                if (nt.typed) want = nt.want;
                resp_q = {resp_q, want};
            end
            if (out_valid && !out_stall) begin
                got = '{parse_status, body_valid, body_byte, response_code};
                if (got.bvalid) body_seen++;
                if (resp_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result %p", got);
                end else begin
                    want = resp_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch: expected st=%0d bv=%0d b=%02h code=%0d",
                                     want.status, want.bvalid, want.bbyte, want.code);
                            $display("          actual   st=%0d bv=%0d b=%02h code=%0d",
                                     got.status, got.bvalid, got.bbyte, got.code);
                        end
                    end
                end
            end
        end
    end

    // Receiver: random stall, one long hold-off on request
    initial
    begin
        out_stall = 1'b1;
        forever
        begin
            @(negedge clk);
            if (squeeze) begin
                out_stall = 1'b1;
                repeat (300) @(negedge clk);
                squeeze = 1'b0;
            end
            out_stall = (!calm && $urandom_range(0, 99) < 33);
        end
    end

    // Offer one item, with a random gap first
    task automatic send_item(logic f, logic [7:0] b, bit typed, result_t want);
        note_t nt;
        if (!calm && $urandom_range(0, 99) < 33) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        nt.typed = typed;
        nt.want = want;
        note_q = {note_q, nt};
        in_valid = 1'b1;
        func = f;
        data_byte = b;
        do @(posedge clk); while (in_stall);
        sent_n++;
        calm = (sent_n > 500 && sent_n < 700);
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_item(FUNC_DATA, s[i], 1'b0, '0);
    endtask

    // Hold off the sender until every result is back
    task automatic drain();
        in_valid = 1'b0;
        wait (resp_q.size() == 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_max_body(logic [23:0] v);
        cfg_we = 1'b1;
        cfg_data = v;
        @(negedge clk);
        cfg_we = 1'b0;
        max_body = v;
    endtask

    // One chunk: size line in random form, random data, CR LF
    task automatic send_chunk(int n);
        string sz;
        sz = $sformatf("%0h", n);
        if ($urandom_range(0, 1)) sz = sz.toupper();
        if ($urandom_range(0, 3) == 0) sz = {"00", sz};
        if ($urandom_range(0, 3) == 0) sz = {sz, " \t"};
        if ($urandom_range(0, 2) == 0) sz = {sz, ";name=", $sformatf("v%0d~", n)};
        send_text({sz, "\r\n"});
        repeat (n) send_item(FUNC_DATA, 8'($urandom_range(0, 255)), 1'b0, '0);
        send_text("\r\n");
    endtask

    // Stimulus
    initial
    begin
        row_t    rows[$];
        row_t    rw;
        ending_e fin;
        result_t none;
        bit      held_off;
        none = '0;
        held_off = 1'b0;
        errors = 0; sent_n = 0; body_seen = 0; cycles = 0;
        calm = 1'b0; squeeze = 1'b0;
        rst_n = 1'b0; cfg_we = 1'b0; cfg_data = '0;
        in_valid = 1'b0; func = FUNC_DATA; data_byte = 8'h00;
        parser_reset();
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        write_max_body(24'hFF_FFFF);

        // Directed: headers and a first chunk
        rows = '{
            '{"HTTP/1.1 200 OK\r\n", 1'b1, '{ST_MORE, 1'b0, 8'h00, 10'd0}},
            '{"Transfer-Encoding:  CHUNKED\r\n", 1'b1, '{ST_MORE, 1'b0, 8'h00, 10'd0}},
            '{"x-Note: \t v\r\n", 1'b0, none},
            '{"\r\n", 1'b1, '{ST_MORE, 1'b0, 8'h00, 10'd200}},
            '{"A;e=1\r\n", 1'b0, none},
            '{"0123456789\r\n", 1'b0, none}
        };
        foreach (rows[i])
        begin
            rw = rows[i];
            for (int k = 0; k < rw.txt.len(); k++)
                send_item(FUNC_DATA, rw.txt[k], rw.typed && k == rw.txt.len() - 1, rw.want);
        end
        send_chunk(1);

        // Random chunked body with a hold-off and register changes
        while (sent_n < 1250)
        begin
            if (sent_n > 300 && !held_off) begin
                squeeze = 1'b1;
                held_off = 1'b1;
            end
            if ($urandom_range(0, 15) == 0) begin
                drain();
                write_max_body(24'(body_cnt + $urandom_range(2000, 100000)));
            end
            send_chunk($urandom_range(1, 40));
        end

        // Close the response one of three ways
        fin = ending_e'($urandom_range(0, 2));
        case (fin)
            END_TRAILER: send_text("0\r\nX-T: 1\r\n\r\n");
            END_NO_ROOM: begin
                drain();
                write_max_body(24'h00_0000);
                send_text("5\r\n");
            end
            default: send_item(FUNC_CLOSE, 8'h00, 1'b0, none);
        endcase

        // Held status: noise of both kinds
        repeat (30) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, none);
        drain();
        repeat (10) @(negedge clk);

        $display("covered %0d items, %0d body bytes out, ending %s, final status %0d",
                 sent_n, body_seen, fin.name(), sticky);
        if (errors == 0 && resp_q.size() == 0)
            $display("http_response_stream_parser_unit_tb: clean");
        else
            $display("http_response_stream_parser_unit_tb: errors");
        $finish;
    end
endmodule

/* http_response_stream_parser_unit.f */
rtl/hrsp_pkg.sv
rtl/hrsp_core.sv
rtl/http_response_stream_parser_unit.sv
rtl/hrsp_checker.sv
bench/http_response_stream_parser_unit_tb.sv
